>>> rtl/text_newline_indent_style_detector_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the newline and indent style detector
// Simulation gets concurrent assertions; synthesis gets empty bodies.
// ----------------------------------------------------------------------------
`ifndef TEXT_NEWLINE_INDENT_STYLE_DETECTOR_DEFINES_SVH
`define TEXT_NEWLINE_INDENT_STYLE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define TNISD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define TNISD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TNISD_ASSERT_ALWAYS(lbl, cond, msg)
`define TNISD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/tnisd_pkg.sv
// ----------------------------------------------------------------------------
// tnisd_pkg
// Types and constants shared by the newline and indent style detector.
// ----------------------------------------------------------------------------
package tnisd_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned NbW  = 3;
  localparam int unsigned CntW = 32;

  localparam logic [CpW-1:0] CH_TAB   = 21'd9;
  localparam logic [CpW-1:0] CH_LF    = 21'd10;
  localparam logic [CpW-1:0] CH_CR    = 21'd13;
  localparam logic [CpW-1:0] CH_SPACE = 21'd32;

  localparam logic [3:0]      INIT_SPACE_RUN  = 4'd8;
  localparam logic [CntW-1:0] LIMIT_RESET     = 32'd1048576;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TAB   = 2'd1,
    KIND_SPACE = 2'd2,
    KIND_MIXED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    NL_UNDECIDED = 2'd0,
    NL_LF        = 2'd1,
    NL_CRLF      = 2'd2,
    NL_CR        = 2'd3
  } newline_e;

  typedef enum logic [1:0] {
    IND_UNDECIDED = 2'd0,
    IND_TABS      = 2'd1,
    IND_SPACES    = 2'd2
  } indent_e;

  typedef struct packed {
    logic [CntW-1:0] cnt_cr;
    logic [CntW-1:0] cnt_lf;
    logic [CntW-1:0] cnt_crlf;
    logic [CntW-1:0] cnt_tab;
    logic [CntW-1:0] cnt_space;
    logic [3:0]      min_run;
  } snap_t;

endpackage

>>> rtl/tnisd_decide.sv
// ----------------------------------------------------------------------------
// tnisd_decide
// Dominance decision on a counter snapshot, with the result register.
// ----------------------------------------------------------------------------
module tnisd_decide (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            snap_valid_i,
  input  tnisd_pkg::snap_t snap_i,
  output logic            snap_ready_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [1:0]      newline_style_o,
  output logic [1:0]      indent_style_o,
  output logic [3:0]      space_width_o
);

  localparam int unsigned CntW = tnisd_pkg::CntW;

  // a > 3 * (b + c), no overflow
  function automatic logic dominates(logic [CntW-1:0] a, logic [CntW-1:0] b,
                                     logic [CntW-1:0] c);
    logic [CntW:0]   sum;
    logic [CntW+2:0] rest;
    sum  = {1'b0, b} + {1'b0, c};
    rest = {1'b0, sum, 1'b0} + {2'b00, sum};
    return {3'b000, a} > rest;
  endfunction

  logic                  res_valid_q;
  tnisd_pkg::newline_e   nl_d, nl_q;
  tnisd_pkg::indent_e    ind_d, ind_q;
  logic [3:0]            width_d, width_q;
  logic                  load;

  assign snap_ready_o = !res_valid_q || res_ready_i;
  assign load         = snap_valid_i && snap_ready_o;

  always_comb begin
    if (dominates(snap_i.cnt_crlf, snap_i.cnt_cr, snap_i.cnt_lf)) begin
      nl_d = tnisd_pkg::NL_CRLF;
    end else if (dominates(snap_i.cnt_cr, snap_i.cnt_crlf, snap_i.cnt_lf)) begin
      nl_d = tnisd_pkg::NL_CR;
    end else if (dominates(snap_i.cnt_lf, snap_i.cnt_crlf, snap_i.cnt_cr)) begin
      nl_d = tnisd_pkg::NL_LF;
    end else begin
      nl_d = tnisd_pkg::NL_UNDECIDED;
    end

    width_d = 4'd0;
    if (dominates(snap_i.cnt_tab, snap_i.cnt_space, '0)) begin
      ind_d = tnisd_pkg::IND_TABS;
    end else if (dominates(snap_i.cnt_space, snap_i.cnt_tab, '0)) begin
      ind_d   = tnisd_pkg::IND_SPACES;
      width_d = snap_i.min_run;
    end else begin
      ind_d = tnisd_pkg::IND_UNDECIDED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      res_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      nl_q    <= nl_d;
      ind_q   <= ind_d;
      width_q <= width_d;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign newline_style_o = nl_q;
  assign indent_style_o  = ind_q;
  assign space_width_o   = width_q;

endmodule

>>> rtl/text_newline_indent_style_detector.sv
// ----------------------------------------------------------------------------
// text_newline_indent_style_detector
// Scans decoded text and reports its newline style, indent style and width.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one code point per transfer with its encoded byte length.
//   m_axis carries one result per text: newline style, indent style and the
//   smallest leading space run. A text ends on a zero code point that comes
//   first or follows a zero, or once the scanned bytes reach the limit set
//   through cfg_we_i / cfg_wdata_i (write only while idle).
//   One code point is taken every cycle while s_axis_tready is high; the line
//   and counter state is updated per item from its own registers. A result
//   for the transfer that ends the text passes the input register, the state
//   update into a counter snapshot, and the decision into the output register.
//   Reset clears all scan state and sets the limit to 1048576 bytes.
//   A stalled m_axis holds its result; the snapshot register and the input
//   register fill behind it, and s_axis_tready drops only when a second text
//   end would need the occupied snapshot.
// ----------------------------------------------------------------------------
`include "text_newline_indent_style_detector_defines.svh"

module text_newline_indent_style_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,     // scan_byte_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // [20:0] code_point, [23:21] char_bytes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata     // [1:0] newline_style, [3:2] indent_style,
                                       // [7:4] space_width
);

  localparam int unsigned CpW  = tnisd_pkg::CpW;
  localparam int unsigned NbW  = tnisd_pkg::NbW;
  localparam int unsigned CntW = tnisd_pkg::CntW;

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    return (&v) ? v : v + CntW'(1);
  endfunction

  // config
  logic [CntW-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tnisd_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // input register
  logic           in_valid_q;
  logic [CpW-1:0] cp_q;
  logic [NbW-1:0] nb_q;
  logic           in_go;

  assign s_axis_tready = !in_valid_q || in_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cp_q <= s_axis_tdata[CpW-1:0];
      nb_q <= s_axis_tdata[CpW+NbW-1:CpW];
    end
  end

  // scan state
  logic                prev_cr_q, prev_cr_d;
  logic                prev_zero_q, prev_zero_d;
  logic                line_start_q, line_start_d;
  tnisd_pkg::kind_e    kind_q, kind_d;
  logic [7:0]          lead_q, lead_d;
  logic [3:0]          min_run_q, min_run_d;
  logic [CntW-1:0]     cnt_cr_q, cnt_cr_d;
  logic [CntW-1:0]     cnt_lf_q, cnt_lf_d;
  logic [CntW-1:0]     cnt_crlf_q, cnt_crlf_d;
  logic [CntW-1:0]     cnt_tab_q, cnt_tab_d;
  logic [CntW-1:0]     cnt_space_q, cnt_space_d;
  logic [CntW-1:0]     bytes_q, bytes_d;

  logic                end_text, limit_hit, emit;
  logic [CntW:0]       byte_sum;
  logic [CntW-1:0]     bytes_upd;
  tnisd_pkg::snap_t    snap_d;

  logic                snap_valid_q;
  tnisd_pkg::snap_t    snap_q;
  logic                snap_ready;
  logic                dec_ready;

  always_comb begin
    prev_cr_d    = prev_cr_q;
    line_start_d = line_start_q;
    kind_d       = kind_q;
    lead_d       = lead_q;
    min_run_d    = min_run_q;
    cnt_cr_d     = cnt_cr_q;
    cnt_lf_d     = cnt_lf_q;
    cnt_crlf_d   = cnt_crlf_q;
    cnt_tab_d    = cnt_tab_q;
    cnt_space_d  = cnt_space_q;

    if (cp_q == tnisd_pkg::CH_TAB && line_start_q) begin
      kind_d = (kind_q == tnisd_pkg::KIND_NONE || kind_q == tnisd_pkg::KIND_TAB) ?
               tnisd_pkg::KIND_TAB : tnisd_pkg::KIND_MIXED;
    end else if (cp_q == tnisd_pkg::CH_SPACE && line_start_q) begin
      kind_d = (kind_q == tnisd_pkg::KIND_NONE || kind_q == tnisd_pkg::KIND_SPACE) ?
               tnisd_pkg::KIND_SPACE : tnisd_pkg::KIND_MIXED;
      if (!(&lead_q)) begin
        lead_d = lead_q + 8'd1;
      end
    end else if (cp_q == tnisd_pkg::CH_CR || cp_q == tnisd_pkg::CH_LF) begin
      if (kind_q == tnisd_pkg::KIND_TAB) begin
        cnt_tab_d = sat_inc(cnt_tab_q);
      end else if (kind_q == tnisd_pkg::KIND_SPACE) begin
        cnt_space_d = sat_inc(cnt_space_q);
        if (lead_q != 8'd0 && lead_q < {4'd0, min_run_q}) begin
          min_run_d = lead_q[3:0];
        end
      end
      line_start_d = 1'b1;
      lead_d       = 8'd0;
      kind_d       = tnisd_pkg::KIND_NONE;
    end else begin
      line_start_d = 1'b0;
    end

    if (prev_cr_q) begin
      if (cp_q == tnisd_pkg::CH_LF) begin
        cnt_crlf_d = sat_inc(cnt_crlf_q);
      end else begin
        cnt_cr_d = sat_inc(cnt_cr_q);
      end
    end else if (cp_q == tnisd_pkg::CH_LF) begin
      cnt_lf_d = sat_inc(cnt_lf_q);
    end

    prev_cr_d   = (cp_q == tnisd_pkg::CH_CR);
    prev_zero_d = (cp_q == '0);

    byte_sum  = {1'b0, bytes_q} + {{(CntW+1-NbW){1'b0}}, nb_q};
    bytes_upd = byte_sum[CntW] ? '1 : byte_sum[CntW-1:0];
    bytes_d   = bytes_upd;

    end_text  = prev_zero_q && (cp_q == '0);
    limit_hit = (bytes_upd >= limit_q);
    emit      = end_text || limit_hit;

    if (end_text) begin
      snap_d = '{cnt_cr: cnt_cr_q, cnt_lf: cnt_lf_q, cnt_crlf: cnt_crlf_q,
                 cnt_tab: cnt_tab_q, cnt_space: cnt_space_q, min_run: min_run_q};
    end else begin
      snap_d = '{cnt_cr: cnt_cr_d, cnt_lf: cnt_lf_d, cnt_crlf: cnt_crlf_d,
                 cnt_tab: cnt_tab_d, cnt_space: cnt_space_d, min_run: min_run_d};
    end
  end

  assign in_go = in_valid_q && (!emit || snap_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cr_q    <= 1'b0;
      prev_zero_q  <= 1'b1;
      line_start_q <= 1'b1;
      kind_q       <= tnisd_pkg::KIND_NONE;
      lead_q       <= 8'd0;
      min_run_q    <= tnisd_pkg::INIT_SPACE_RUN;
      cnt_cr_q     <= '0;
      cnt_lf_q     <= '0;
      cnt_crlf_q   <= '0;
      cnt_tab_q    <= '0;
      cnt_space_q  <= '0;
      bytes_q      <= '0;
    end else if (in_go) begin
      if (emit) begin
        prev_cr_q    <= 1'b0;
        prev_zero_q  <= 1'b1;
        line_start_q <= 1'b1;
        kind_q       <= tnisd_pkg::KIND_NONE;
        lead_q       <= 8'd0;
        min_run_q    <= tnisd_pkg::INIT_SPACE_RUN;
        cnt_cr_q     <= '0;
        cnt_lf_q     <= '0;
        cnt_crlf_q   <= '0;
        cnt_tab_q    <= '0;
        cnt_space_q  <= '0;
        bytes_q      <= '0;
      end else begin
        prev_cr_q    <= prev_cr_d;
        prev_zero_q  <= prev_zero_d;
        line_start_q <= line_start_d;
        kind_q       <= kind_d;
        lead_q       <= lead_d;
        min_run_q    <= min_run_d;
        cnt_cr_q     <= cnt_cr_d;
        cnt_lf_q     <= cnt_lf_d;
        cnt_crlf_q   <= cnt_crlf_d;
        cnt_tab_q    <= cnt_tab_d;
        cnt_space_q  <= cnt_space_d;
        bytes_q      <= bytes_d;
      end
    end
  end

  // counter snapshot
  assign snap_ready = !snap_valid_q || dec_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (snap_ready) begin
      snap_valid_q <= in_go && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && emit) begin
      snap_q <= snap_d;
    end
  end

  tnisd_decide u_decide (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .snap_valid_i    (snap_valid_q),
    .snap_i          (snap_q),
    .snap_ready_o    (dec_ready),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .newline_style_o (m_axis_tdata[1:0]),
    .indent_style_o  (m_axis_tdata[3:2]),
    .space_width_o   (m_axis_tdata[7:4])
  );

  `TNISD_ASSERT_NEXT(a_clear_after_emit, in_go && emit,
    bytes_q == '0 && cnt_cr_q == '0 && cnt_lf_q == '0 && prev_zero_q,
    "scan state not cleared after text end")
  `TNISD_ASSERT_ALWAYS(a_min_run_range, min_run_q != 4'd0 && min_run_q <= 4'd8,
    "minimum space run out of range")
  `TNISD_ASSERT_ALWAYS(a_prev_flags, !(prev_cr_q && prev_zero_q),
    "previous CR and previous zero both set")
  `TNISD_ASSERT_NEXT(a_snap_hold, snap_valid_q && !dec_ready,
    snap_valid_q && $stable(snap_q), "stalled counter snapshot changed")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: newline and indent style detector regression
// Streams short texts of code points into the detector and checks every style
// result against a cycle-free predictor of the scan or a typed table value.
// A directed table covers end-of-text rules, byte limits, pending CR and odd
// field values; the random part sends line-structured texts under several
// byte limits, with idle bursts on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [3:0]           width;
    tnisd_pkg::indent_e   ind;
    tnisd_pkg::newline_e  nl;
  } style_t;

  typedef enum logic {ROW_CHAR, ROW_LIMIT} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] arg;    // limit value, or {8'd0, char_bytes, code_point}
    logic        typed;
    style_t      want;
  } plan_row_t;

  localparam style_t EMPTY_TEXT = '{4'd0, tnisd_pkg::IND_UNDECIDED, tnisd_pkg::NL_UNDECIDED};
  localparam style_t LF_ONLY    = '{4'd0, tnisd_pkg::IND_UNDECIDED, tnisd_pkg::NL_LF};

  localparam int PlanLen = 29;
  localparam plan_row_t PLAN [PlanLen] = '{
    '{ROW_CHAR,  {8'd0, 3'd1, 21'd0},                1'b1, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, tnisd_pkg::CH_TAB},    1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, tnisd_pkg::CH_SPACE},  1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd0, 21'h78},               1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, tnisd_pkg::CH_CR},     1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd4, tnisd_pkg::CH_LF},     1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd7, tnisd_pkg::CH_TAB},    1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd2, 21'h1FFFFF},           1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd3, tnisd_pkg::CH_CR},     1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, tnisd_pkg::CH_SPACE},  1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, 21'h7A},               1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, 21'd0},                1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, 21'd0},                1'b0, EMPTY_TEXT},
    '{ROW_LIMIT, 32'd1,                              1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, 21'h41},               1'b1, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, tnisd_pkg::CH_LF},     1'b1, LF_ONLY},
    '{ROW_LIMIT, 32'd0,                              1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd0, 21'h41},               1'b1, EMPTY_TEXT},
    '{ROW_LIMIT, 32'd6,                              1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, tnisd_pkg::CH_SPACE},  1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, tnisd_pkg::CH_SPACE},  1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, 21'h71},               1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, tnisd_pkg::CH_LF},     1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd2, tnisd_pkg::CH_CR},     1'b0, EMPTY_TEXT},
    '{ROW_LIMIT, 32'hFFFF_FFFF,                      1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd4, 21'h10FFFF},           1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, tnisd_pkg::CH_LF},     1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, 21'd0},                1'b0, EMPTY_TEXT},
    '{ROW_CHAR,  {8'd0, 3'd1, 21'd0},                1'b0, EMPTY_TEXT}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  text_newline_indent_style_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor state
  logic [31:0]       byte_limit;
  logic              cr_pending;
  logic              zero_seen;
  logic              line_start;
  tnisd_pkg::kind_e  line_kind;
  logic [7:0]        lead_spaces;
  logic [3:0]        min_run;
  logic [31:0]       n_cr, n_lf, n_crlf, n_tab_lines, n_space_lines, n_bytes;

  style_t awaited_styles[$];
  int     bad_results;
  int     chars_sent;
  bit     calm;
  bit     hold_req;

  function automatic void clear_scan();
    cr_pending    = 1'b0;
    zero_seen     = 1'b1;
    line_start    = 1'b1;
    line_kind     = tnisd_pkg::KIND_NONE;
    lead_spaces   = 8'd0;
    min_run       = tnisd_pkg::INIT_SPACE_RUN;
    n_cr          = '0;
    n_lf          = '0;
    n_crlf        = '0;
    n_tab_lines   = '0;
    n_space_lines = '0;
    n_bytes       = '0;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic bit beats(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [63:0] rest;
    rest = ({32'd0, b} + {32'd0, c}) * 64'd3;
    return {32'd0, a} > rest;
  endfunction

  function automatic style_t decide_styles();
    style_t res;
    res = EMPTY_TEXT;
    if (beats(n_crlf, n_cr, n_lf)) res.nl = tnisd_pkg::NL_CRLF;
    else if (beats(n_cr, n_crlf, n_lf)) res.nl = tnisd_pkg::NL_CR;
    else if (beats(n_lf, n_crlf, n_cr)) res.nl = tnisd_pkg::NL_LF;
    if (beats(n_tab_lines, n_space_lines, 32'd0)) begin
      res.ind = tnisd_pkg::IND_TABS;
    end else if (beats(n_space_lines, n_tab_lines, 32'd0)) begin
      res.ind   = tnisd_pkg::IND_SPACES;
      res.width = min_run;
    end
    return res;
  endfunction

  // advances the scan by one code point; returns 1 when a text ends
  function automatic bit scan_char(input logic [20:0] cp, input logic [2:0] nb,
                                   output style_t res);
    logic [32:0] sum;
    res = EMPTY_TEXT;
    if (zero_seen && cp == 21'd0) begin
      res = decide_styles();
      clear_scan();
      return 1'b1;
    end
    if (cp == tnisd_pkg::CH_TAB && line_start) begin
      if (line_kind == tnisd_pkg::KIND_NONE || line_kind == tnisd_pkg::KIND_TAB)
        line_kind = tnisd_pkg::KIND_TAB;
      else line_kind = tnisd_pkg::KIND_MIXED;
    end else if (cp == tnisd_pkg::CH_SPACE && line_start) begin
      if (line_kind == tnisd_pkg::KIND_NONE || line_kind == tnisd_pkg::KIND_SPACE)
        line_kind = tnisd_pkg::KIND_SPACE;
      else line_kind = tnisd_pkg::KIND_MIXED;
      if (lead_spaces != 8'hFF) lead_spaces = lead_spaces + 8'd1;
    end else if (cp == tnisd_pkg::CH_CR || cp == tnisd_pkg::CH_LF) begin
      if (line_kind == tnisd_pkg::KIND_TAB) begin
        n_tab_lines = sat_inc(n_tab_lines);
      end else if (line_kind == tnisd_pkg::KIND_SPACE) begin
        n_space_lines = sat_inc(n_space_lines);
        if (lead_spaces != 8'd0 && lead_spaces < {4'd0, min_run}) min_run = lead_spaces[3:0];
      end
      line_start  = 1'b1;
      lead_spaces = 8'd0;
      line_kind   = tnisd_pkg::KIND_NONE;
    end else begin
      line_start = 1'b0;
    end
    if (cr_pending) begin
      if (cp == tnisd_pkg::CH_LF) n_crlf = sat_inc(n_crlf);
      else n_cr = sat_inc(n_cr);
    end else if (cp == tnisd_pkg::CH_LF) begin
      n_lf = sat_inc(n_lf);
    end
    cr_pending = (cp == tnisd_pkg::CH_CR);
    zero_seen  = (cp == 21'd0);
    sum = {1'b0, n_bytes} + {30'd0, nb};
    n_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (n_bytes >= byte_limit) begin
      res = decide_styles();
      clear_scan();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [23:0] rand_char();
    logic [20:0] cp;
    logic [2:0]  nb;
    case ($urandom_range(0, 19))
      0: begin
        cp = 21'($urandom_range(0, 21'h1FFFFF));
        nb = 3'($urandom_range(0, 7));
      end
      1: begin
        cp = 21'($urandom_range(21'h80, 21'h7FF));
        nb = 3'd2;
      end
      2: begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        nb = 3'd3;
      end
      3: begin
        cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        nb = 3'd4;
      end
      4: begin
        cp = $urandom_range(0, 1) ? tnisd_pkg::CH_TAB : tnisd_pkg::CH_SPACE;
        nb = 3'd1;
      end
      default: begin
        cp = 21'($urandom_range(21'h21, 21'h7E));
        nb = 3'd1;
      end
    endcase
    return {nb, cp};
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("text_newline_indent_style_detector regression: fail");
    $finish;
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (399) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    style_t got;
    style_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (awaited_styles.size() == 0) begin
        if (bad_results < 10) $display("unexpected result transfer: %h", m_axis_tdata);
        bad_results++;
      end else begin
        want = awaited_styles.pop_front();
        if (got.nl !== want.nl || got.ind !== want.ind || got.width !== want.width) begin
          if (bad_results < 10)
            $display("mismatch: expected nl=%0d ind=%0d width=%0d, got nl=%0d ind=%0d width=%0d",
                     want.nl, want.ind, want.width, got.nl, got.ind, got.width);
          bad_results++;
        end
      end
    end
  end

  task automatic push_char(input logic [20:0] cp, input logic [2:0] nb,
                           input bit typed = 1'b0, input style_t want = EMPTY_TEXT);
    style_t res;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {nb, cp};
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
    if (scan_char(cp, nb, res)) awaited_styles.push_back(typed ? want : res);
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (awaited_styles.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [31:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    byte_limit = v;
  endtask

  task automatic lead_in(input int kind, input int width);
    int pick;
    int n;
    pick = (kind == 3) ? $urandom_range(1, 3) : kind;
    case (pick)
      1: repeat ($urandom_range(1, 3)) push_char(tnisd_pkg::CH_TAB, 3'd1);
      2: begin
        if ($urandom_range(0, 60) == 0) n = $urandom_range(250, 270);
        else if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 12);
        else n = width * $urandom_range(1, 2);
        repeat (n) push_char(tnisd_pkg::CH_SPACE, 3'd1);
      end
      default: repeat ($urandom_range(2, 6))
        push_char($urandom_range(0, 1) ? tnisd_pkg::CH_TAB : tnisd_pkg::CH_SPACE, 3'd1);
    endcase
  endtask

  task automatic body(input int n);
    logic [23:0] ch;
    repeat (n) begin
      ch = rand_char();
      push_char(ch[20:0], ch[23:21]);
    end
  endtask

  // one text: lines with a preferred newline and indent style, then a zero pair
  task automatic send_text();
    int lines;
    int nl_pick;
    int ind_pick;
    int width;
    int s;
    lines    = $urandom_range(0, 8);
    nl_pick  = $urandom_range(0, 3);
    ind_pick = $urandom_range(0, 3);
    width    = $urandom_range(1, 9);
    for (int i = 0; i < lines; i++) begin
      if (ind_pick != 0 && $urandom_range(0, 3) != 0) lead_in(ind_pick, width);
      body($urandom_range(0, 5));
      s = (nl_pick == 3 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : nl_pick;
      case (s)
        0: push_char(tnisd_pkg::CH_LF, 3'd1);
        1: begin
          push_char(tnisd_pkg::CH_CR, 3'd1);
          push_char(tnisd_pkg::CH_LF, 3'd1);
        end
        default: push_char(tnisd_pkg::CH_CR, 3'd1);
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      lead_in((ind_pick == 0) ? 2 : ind_pick, width);
      body($urandom_range(0, 3));
    end
    push_char(21'd0, 3'd1);
    push_char(21'd0, 3'd1);
  endtask

  initial begin
    int phase_end;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    bad_results   = 0;
    chars_sent    = 0;
    byte_limit    = tnisd_pkg::LIMIT_RESET;
    clear_scan();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < PlanLen; r++) begin
      if (PLAN[r].kind == ROW_LIMIT) set_limit(PLAN[r].arg);
      else push_char(PLAN[r].arg[20:0], PLAN[r].arg[23:21], PLAN[r].typed, PLAN[r].want);
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_limit(tnisd_pkg::LIMIT_RESET);
        1: set_limit($urandom_range(20, 80));
        2: set_limit($urandom_range(1, 8));
        3: set_limit(32'hFFFF_FFFF);
        default: set_limit($urandom_range(9, 150));
      endcase
      if (p == 1) hold_req = 1'b1;
      if (p == 4) calm = 1'b1;
      phase_end = chars_sent + 220;
      while (chars_sent < phase_end) send_text();
    end

    drain();
    if (awaited_styles.size() != 0) bad_results++;
    if (bad_results == 0) begin
      $display("text_newline_indent_style_detector regression: pass");
    end else begin
      $display("text_newline_indent_style_detector regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tnisd_pkg.sv
rtl/tnisd_decide.sv
rtl/text_newline_indent_style_detector.sv
tb/tb_top.sv
